FILE: hw/rtl/ave_pkg.sv
// shared constants and types for the angle velocity estimator
// no dependencies; imported by angle_velocity_estimator
`timescale 1ns / 1ps

package ave_pkg;

   localparam int ANGLE_BITS_DEF = 16;

   // field and register widths
   localparam int POS_W  = 16;
   localparam int VEL_W  = 36;
   localparam int TPOS_W = 48;
   localparam int GAIN_W = 16;
   localparam int RATE_W = 20;
   localparam int LAP_W  = 32;
   localparam int FRAC_W = 16;

   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_INDEX_W = 1;

   localparam logic [RATE_W-1:0] RATE_LIMIT = 20'd1000000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
   localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILTER_GAIN = 1'b0,
      REG_RATE_SCALE  = 1'b1
   } reg_index_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RATE = 7'b0000010,
      S_DIFF = 7'b0000100,
      S_HI   = 7'b0001000,
      S_LO   = 7'b0010000,
      S_ADD  = 7'b0100000,
      S_OUT  = 7'b1000000
   } seq_state_type;

endpackage

FILE: hw/rtl/ave_mul.sv
// shared signed multiplier with a registered product
// used by angle_velocity_estimator for the rate and filter gain products
`timescale 1ns / 1ps

module ave_mul #(
   parameter int AW = 37,
   parameter int BW = 21
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    mul_a,
   input  logic signed [BW-1:0]    mul_b,
   output logic signed [AW+BW-1:0] mul_p_ff
);

   logic signed [AW+BW-1:0] mul_p_in;

   always_comb begin
      mul_p_in = (AW+BW)'(mul_a) * (AW+BW)'(mul_b);
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

endmodule

FILE: hw/rtl/angle_velocity_estimator.sv
// Angle velocity estimator: each request carries an angle (2^ANGLE_BITS counts per turn).
// A start transfer seeds the angle and clears laps and filter; an update transfer takes the
// wrapped difference, multiplies it by rate_scale and runs a Q.16 first-order low pass.
// Start and invalid-rate transfers go straight to S_OUT; updates step through S_RATE, S_DIFF,
// S_HI, S_LO and S_ADD first, and S_OUT loads the result register once rsp_tready allows:
// one signed multiplier is shared for the rate product and the two halves of the gain
// product, stepped by a small sequencer; req_tready is low while an item is in work.
// Depends on ave_pkg and ave_mul.
`timescale 1ns / 1ps

module angle_velocity_estimator #(
   parameter int ANGLE_BITS = ave_pkg::ANGLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ave_pkg::REQ_DATA_W-1:0]       req_tdata,   // position
   input  logic [0:0]                           req_tuser,   // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ave_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // velocity, total_position
   output logic [0:0]                           rsp_tuser,   // rate_invalid
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ave_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ave_pkg::RATE_W-1:0]           csr_data
);

   import ave_pkg::*;

   localparam int PosW = (ANGLE_BITS < POS_W) ? ANGLE_BITS : POS_W;
   localparam int RawW = ANGLE_BITS + 2;
   localparam int YW   = ANGLE_BITS + RATE_W + FRAC_W;
   localparam int DW   = YW + 1;
   localparam int MA   = DW - FRAC_W;
   localparam int MB   = RATE_W + 1;
   localparam int PW   = MA + MB;

   localparam logic signed [RawW-1:0] HalfTurn = signed'(RawW'(1) << (ANGLE_BITS - 1));
   localparam logic signed [RawW-1:0] FullTurn = signed'(RawW'(1) << ANGLE_BITS);

   seq_state_type             state_ff, state_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic [RATE_W-1:0]         rate_ff, rate_in;
   logic [PosW-1:0]           prev_ff, prev_in;
   logic signed [LAP_W-1:0]   lap_ff, lap_in;
   logic signed [YW-1:0]      y_ff, y_in;
   logic signed [ANGLE_BITS-1:0] delta_ff, delta_in;
   logic signed [DW-1:0]      diff_ff, diff_in;
   logic                      invalid_ff, invalid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VEL_W-1:0]          vel_ff, vel_in;
   logic [TPOS_W-1:0]         tpos_ff, tpos_in;
   logic                      rsp_inv_ff, rsp_inv_in;

   logic signed [MA-1:0]      mul_a;
   logic signed [MB-1:0]      mul_b;
   logic signed [PW-1:0]      mul_p_ff;

   logic                      req_xfer;
   logic [PosW-1:0]           pos;
   logic signed [RawW-1:0]    raw;
   logic                      rate_bad;
   logic signed [DW-1:0]      x_q;
   logic signed [TPOS_W-1:0]  lap_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign pos        = req_tdata[PosW-1:0];
   assign raw        = signed'(RawW'(pos)) - signed'(RawW'(prev_ff));
   assign rate_bad   = (rate_ff == '0) || (rate_ff >= RATE_LIMIT);
   assign x_q        = signed'({mul_p_ff[DW-FRAC_W-1:0], {FRAC_W{1'b0}}});
   assign lap_ext    = TPOS_W'(lap_ff);

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         S_RATE: begin
            mul_a = MA'(delta_ff);
            mul_b = MB'({1'b0, rate_ff});
         end
         S_HI: begin
            mul_a = MA'(diff_ff >>> FRAC_W);
            mul_b = MB'({1'b0, gain_ff});
         end
         default: begin
            mul_a = MA'({1'b0, diff_ff[FRAC_W-1:0]});
            mul_b = MB'({1'b0, gain_ff});
         end
      endcase
   end

   ave_mul #(
      .AW (MA),
      .BW (MB)
   ) u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p_ff (mul_p_ff)
   );

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      rate_in      = rate_ff;
      prev_in      = prev_ff;
      lap_in       = lap_ff;
      y_in         = y_ff;
      delta_in     = delta_ff;
      diff_in      = diff_ff;
      invalid_in   = invalid_ff;
      rsp_valid_in = rsp_valid_ff;
      vel_in       = vel_ff;
      tpos_in      = tpos_ff;
      rsp_inv_in   = rsp_inv_ff;

      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_FILTER_GAIN: gain_in = csr_data[GAIN_W-1:0];
            REG_RATE_SCALE:  rate_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               invalid_in = 1'b0;
               state_in   = S_OUT;
               if (req_tuser[0]) begin
                  prev_in = pos;
                  lap_in  = '0;
                  y_in    = '0;
               end else if (rate_bad) begin
                  invalid_in = 1'b1;
               end else begin
                  prev_in  = pos;
                  state_in = S_RATE;
                  if (raw >= HalfTurn) begin
                     delta_in = ANGLE_BITS'(raw - FullTurn);
                     lap_in   = lap_ff - LAP_W'(1);
                  end else if (raw < -HalfTurn) begin
                     delta_in = ANGLE_BITS'(raw + FullTurn);
                     lap_in   = lap_ff + LAP_W'(1);
                  end else begin
                     delta_in = ANGLE_BITS'(raw);
                  end
               end
            end
         end
         S_RATE: state_in = S_DIFF;
         S_DIFF: begin
            diff_in  = x_q - DW'(y_ff);
            state_in = S_HI;
         end
         S_HI: state_in = S_LO;
         S_LO: begin
            y_in     = y_ff + YW'(mul_p_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            y_in     = y_ff + signed'(YW'(mul_p_ff[FRAC_W+GAIN_W-1:FRAC_W]));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               vel_in       = VEL_W'(y_ff >>> FRAC_W);
               tpos_in      = TPOS_W'((lap_ext <<< ANGLE_BITS) + signed'(TPOS_W'(prev_ff)));
               rsp_inv_in   = invalid_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= GAIN_RESET;
         rate_ff      <= RATE_RESET;
         prev_ff      <= '0;
         lap_ff       <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         rate_ff      <= rate_in;
         prev_ff      <= prev_in;
         lap_ff       <= lap_in;
         y_ff         <= y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      diff_ff    <= diff_in;
      invalid_ff <= invalid_in;
      vel_ff     <= vel_in;
      tpos_ff    <= tpos_in;
      rsp_inv_ff <= rsp_inv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TPOS_W - VEL_W){1'b0}}, tpos_ff, vel_ff};
   assign rsp_tuser  = rsp_inv_ff;

endmodule
